// ===== src/audio_sample_byte_scrambler_defines.svh =====
// assertion macros shared by the scrambler rtl
// no dependencies; include by bare file name inside a module body
`ifndef AUDIO_SAMPLE_BYTE_SCRAMBLER_DEFINES_SVH
`define AUDIO_SAMPLE_BYTE_SCRAMBLER_DEFINES_SVH
`ifndef SYNTHESIS
// property checked only out of reset
`define ASBS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scrambler check failed");
// property checked at every edge, reset included
`define ASBS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scrambler check failed");
`else
`define ASBS_ASSERT(label, prop)
`define ASBS_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== src/asbs_pkg.sv =====
// types, constants and lookup tables of the audio sample byte scrambler
// no dependencies; used by asbs_scramble and audio_sample_byte_scrambler
`default_nettype none

package asbs_pkg;

  localparam int SAMPLE_W = 24;
  localparam int WORD_W   = 32;

  // marker byte in bits 31:24 of every encoded word
  localparam logic [7:0] WORD_MARK = 8'h40;
  // run position saturates here
  localparam logic [3:0] POS_MAX = 4'd15;
  // high seed nibble that bypasses the high table
  localparam logic [3:0] HI_DIRECT = 4'h9;
  // table period and base offset of the low index
  localparam logic [4:0] TBL_PERIOD = 5'd15;
  localparam logic [4:0] LOW_BASE   = 5'd14;

  // one transaction handed to the scrambler core
  typedef struct packed {
    logic                fire;
    logic [SAMPLE_W-1:0] sample;
  } asbs_step_t;

  // run length per low seed nibble
  function automatic logic [3:0] run_len(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0:  r = 4'd0;
      4'd1:  r = 4'd1;
      4'd2:  r = 4'd3;
      4'd3:  r = 4'd5;
      4'd4:  r = 4'd7;
      4'd5:  r = 4'd9;
      4'd6:  r = 4'd11;
      4'd7:  r = 4'd13;
      4'd8:  r = 4'd14;
      4'd9:  r = 4'd12;
      4'd10: r = 4'd10;
      4'd11: r = 4'd8;
      4'd12: r = 4'd6;
      4'd13: r = 4'd4;
      4'd14: r = 4'd2;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // low carry nibble sequence
  function automatic logic [3:0] low_nib(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0:  r = 4'h8;
      4'd1:  r = 4'h7;
      4'd2:  r = 4'h9;
      4'd3:  r = 4'h6;
      4'd4:  r = 4'ha;
      4'd5:  r = 4'h5;
      4'd6:  r = 4'hb;
      4'd7:  r = 4'h4;
      4'd8:  r = 4'hc;
      4'd9:  r = 4'h3;
      4'd10: r = 4'hd;
      4'd11: r = 4'h2;
      4'd12: r = 4'he;
      4'd13: r = 4'h1;
      4'd14: r = 4'hf;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  // high carry nibble sequence
  function automatic logic [3:0] high_nib(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0:  r = 4'h0;
      4'd1:  r = 4'h6;
      4'd2:  r = 4'hf;
      4'd3:  r = 4'h8;
      4'd4:  r = 4'h7;
      4'd5:  r = 4'h5;
      4'd6:  r = 4'h3;
      4'd7:  r = 4'h4;
      4'd8:  r = 4'hc;
      4'd9:  r = 4'hd;
      4'd10: r = 4'he;
      4'd11: r = 4'h1;
      4'd12: r = 4'h2;
      4'd13: r = 4'hb;
      4'd14: r = 4'ha;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  // start offset into the high sequence per high seed nibble
  function automatic logic [3:0] high_start(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0:  r = 4'd0;
      4'd1:  r = 4'd11;
      4'd2:  r = 4'd12;
      4'd3:  r = 4'd6;
      4'd4:  r = 4'd7;
      4'd5:  r = 4'd5;
      4'd6:  r = 4'd1;
      4'd7:  r = 4'd4;
      4'd8:  r = 4'd3;
      4'd9:  r = 4'd0;
      4'd10: r = 4'd14;
      4'd11: r = 4'd13;
      4'd12: r = 4'd8;
      4'd13: r = 4'd9;
      4'd14: r = 4'd10;
      default: r = 4'd2;
    endcase
    return r;
  endfunction

  // carry byte for the given seed and run position
  function automatic logic [7:0] next_carry(input logic [7:0] seed, input logic [3:0] pos);
    logic [3:0] len;
    logic [3:0] hr;
    logic [4:0] hsum;
    logic [4:0] lsum;
    len  = run_len(seed[3:0]);
    hsum = {1'b0, high_start(seed[7:4])} + {1'b0, pos};
    if (hsum >= TBL_PERIOD) begin
      hsum = hsum - TBL_PERIOD;
    end
    hr   = (seed[7:4] == HI_DIRECT) ? HI_DIRECT : high_nib(hsum[3:0]);
    // used only when pos <= len; the low index then stays within 1..14 for pos >= 1
    lsum = LOW_BASE + {1'b0, pos} - {1'b0, len};
    if (len < pos) begin
      return 8'h00;
    end
    return {hr, low_nib(lsum[3:0])};
  endfunction

endpackage

`default_nettype wire

// ===== src/asbs_scramble.sv =====
// scrambler core: carry, seed and run position state plus the word former
// depends on asbs_pkg
`default_nettype none

module asbs_scramble (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire asbs_pkg::asbs_step_t          step,
  output logic [asbs_pkg::WORD_W-1:0]        word
);
  import asbs_pkg::*;

  logic [7:0] carry_r, carry_nxt;
  logic [7:0] seed_r, seed_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] mid;
  logic       restart;
  logic [3:0] pos_base;

  // restart the run on a nonzero middle byte, then advance the position
  always_comb begin
    mid      = step.sample[15:8];
    restart  = (mid != 8'h00);
    pos_base = restart ? 4'd0 : pos_r;
    seed_nxt = restart ? (mid ^ carry_r) : seed_r;
    pos_nxt  = (pos_base == POS_MAX) ? POS_MAX : pos_base + 4'd1;
    carry_nxt = next_carry(seed_nxt, pos_nxt);
  end

  // encoded word uses the carry held before this transaction
  assign word = {WORD_MARK, step.sample[23:16], mid ^ carry_r, step.sample[7:0]};

  // state update once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= 8'h00;
      seed_r  <= 8'h00;
      pos_r   <= 4'd0;
    end else if (step.fire) begin
      carry_r <= carry_nxt;
      seed_r  <= seed_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/audio_sample_byte_scrambler.sv =====
// audio sample byte scrambler: input register, scrambler core, output register
// two register stages: s1 input register, then the out_tvalid output register
// throughput: one item per cycle unless stalled, set by the carry recurrence
// reset: synchronous active-low rst_n clears both valid flags and the carry,
// seed and run position state
`default_nettype none

module audio_sample_byte_scrambler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [asbs_pkg::SAMPLE_W-1:0] in_tdata,   // [23:0] sample_bits
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [asbs_pkg::WORD_W-1:0]        out_tdata   // [31:0] encoded_word
);
  import asbs_pkg::*;
  `include "audio_sample_byte_scrambler_defines.svh"

  logic                s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_W-1:0] s1_data_r;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_data_r;
  logic                out_free;
  logic                in_fire;
  asbs_step_t          step;
  logic [WORD_W-1:0]   word;

  // pipeline advance
  always_comb begin
    out_free      = !out_valid_r || out_tready;
    in_tready     = !s1_valid_r || out_free;
    in_fire       = in_tvalid && in_tready;
    step.fire     = s1_valid_r && out_free;
    step.sample   = s1_data_r;
    s1_valid_nxt  = in_fire ? 1'b1 : (step.fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = step.fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  asbs_scramble u_scramble (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .word  (word)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
    end
    if (step.fire) begin
      out_data_r <= word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `ASBS_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid)
  `ASBS_ASSERT_ALWAYS(a_ready_follows_sink, out_tready |-> in_tready)
  `ASBS_ASSERT(a_held_item_kept, (s1_valid_r && !out_free) |=> s1_valid_r)
  `ASBS_ASSERT(a_mark_byte, out_tvalid |-> (out_tdata[31:24] == WORD_MARK))

endmodule

`default_nettype wire
